// ===== rtl/layered_rate_adaptation_picker_assert.svh =====
// Assertion macros used by the checker file.
// All macros sample on clk and are disabled while arst_n is low.
`ifndef LAYERED_RATE_ADAPTATION_PICKER_ASSERT_SVH
`define LAYERED_RATE_ADAPTATION_PICKER_ASSERT_SVH

// Same-cycle implication.
`define LRAP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// Next-cycle implication.
`define LRAP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

// ===== rtl/lrap_pkg.sv =====
// ----------------------------------------------------------------------------
// lrap_pkg
// Shared widths and register codes of the layered rate adaptation picker.
// ----------------------------------------------------------------------------
package lrap_pkg;

	localparam int RATE_W    = 20;
	localparam int LEVEL_W   = 16;
	localparam int FILL_W    = 11;
	localparam int WEIGHT_W  = 9;
	localparam int LAYER_W   = 2;
	localparam int SEG_W     = 16;
	localparam int CNT_W     = 3;
	localparam int NUM_RATES = 4;

	// average is Q20.8
	localparam int AVG_W   = RATE_W + 8;
	// shared multiply-accumulate unit
	localparam int MUL_A_W = AVG_W;
	localparam int MUL_B_W = WEIGHT_W;
	localparam int MUL_Y_W = MUL_A_W + MUL_B_W + 1;
	// scaled compare operands: (rate << 8) * 5 and avg * 6
	localparam int CMP_W   = AVG_W + 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RATE_W;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMA_WEIGHT     = 3'd0,
		REG_MIN_BUFFER     = 3'd1,
		REG_GROWING_MARGIN = 3'd2,
		REG_TOTAL_SEGMENTS = 3'd3,
		REG_LAYER0_RATE    = 3'd4,
		REG_LAYER1_RATE    = 3'd5,
		REG_LAYER2_RATE    = 3'd6,
		REG_LAYER3_RATE    = 3'd7
	} cfg_reg_t;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd26;
	localparam logic [LEVEL_W-1:0]  MIN_BUF_RESET = 16'd4000;
	localparam logic [FILL_W-1:0]   FILL_HALF    = 11'd512;
	localparam logic [MUL_B_W-1:0]  SCALE_NUM    = 9'd6;
	localparam logic [MUL_B_W-1:0]  SCALE_UNIT   = 9'd1;

endpackage

// ===== rtl/lrap_mac.sv =====
// ----------------------------------------------------------------------------
// lrap_mac
// Shared unsigned multiply-accumulate unit: y = a * b + c.
// ----------------------------------------------------------------------------
module lrap_mac (
	input  logic [lrap_pkg::MUL_A_W-1:0] a,
	input  logic [lrap_pkg::MUL_B_W-1:0] b,
	input  logic [lrap_pkg::MUL_Y_W-1:0] c,
	output logic [lrap_pkg::MUL_Y_W-1:0] y
);
	import lrap_pkg::*;

	logic [MUL_Y_W-1:0] prod;

	assign prod = MUL_Y_W'(a) * MUL_Y_W'(b);
	assign y    = prod + c;

endmodule

// ===== rtl/layered_rate_adaptation_picker.sv =====
// ----------------------------------------------------------------------------
// layered_rate_adaptation_picker
// Rate-based layer picker for layered adaptive streaming.
// ----------------------------------------------------------------------------
// Each request (last rate, buffer level, buffer fill) returns one result: the
// layer to fetch, the segment number and an all-done flag. A single 28x9
// multiply-accumulate unit does the moving average in two steps and, when a
// new layer set is chosen, forms the compare limit; the layer rates are then
// scanned one per cycle. A request that pops an already stacked layer or hits
// the low-buffer case steps through MUL1, MUL2 and FIN; one that refills the
// stack also passes LIM and SCAN before FIN. The result sits in an output
// register; a new request is taken only while the sequencer is idle, and a
// finished result waits in the last step until the previous one is taken.
module layered_rate_adaptation_picker #(
	parameter int MAX_LAYERS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [19:0] last_rate, [35:20] buffer_level, [46:36] buffer_fill, [47] zero
	input  logic [lrap_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] layer, [17:2] segment_number, [18] all_done, [23:19] zero
	output logic [lrap_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                            cfg_we,
	input  logic [lrap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrap_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lrap_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL1 = 6'b000010,
		ST_MUL2 = 6'b000100,
		ST_LIM  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [WEIGHT_W-1:0] ema_weight_q;
	logic [LEVEL_W-1:0]  min_buffer_q;
	logic [LEVEL_W-1:0]  margin_q;
	logic [SEG_W-1:0]    total_seg_q;
	logic [RATE_W-1:0]   layer_rate_q [NUM_RATES];

	// request
	logic [RATE_W-1:0]  rate_q;
	logic [LEVEL_W-1:0] level_q;
	logic [FILL_W-1:0]  fill_q;

	// state
	logic [AVG_W-1:0]   avg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LAYER_W-1:0] top_q;
	logic [SEG_W-1:0]   seg_q;

	// working registers
	logic [MUL_Y_W-1:0] acc_q;
	logic [CMP_W-1:0]   lim_q;
	logic               pick_q;
	logic               scaled_q;
	logic [LAYER_W-1:0] idx_q;
	logic [LAYER_W-1:0] best_q;
	logic [RATE_W-1:0]  best_rate_q;

	// output register
	logic               m_valid_q;
	logic [LAYER_W-1:0] out_layer_q;
	logic [SEG_W-1:0]   out_seg_q;
	logic               out_done_q;

	logic [WEIGHT_W-1:0] w_eff;
	logic [MUL_A_W-1:0]  mac_a;
	logic [MUL_B_W-1:0]  mac_b;
	logic [MUL_Y_W-1:0]  mac_c;
	logic [MUL_Y_W-1:0]  mac_y;

	lrap_mac u_mac (
		.a (mac_a),
		.b (mac_b),
		.c (mac_c),
		.y (mac_y)
	);

	assign w_eff = (ema_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight_q;

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		unique case (state_q)
			ST_MUL1: begin
				mac_a = {rate_q, 8'b0};
				mac_b = w_eff;
			end
			ST_MUL2: begin
				mac_a = avg_q;
				mac_b = WEIGHT_ONE - w_eff;
				mac_c = acc_q;
			end
			ST_LIM: begin
				mac_a = avg_q;
				mac_b = scaled_q ? SCALE_NUM : SCALE_UNIT;
			end
			default: begin
			end
		endcase
	end

	// low-buffer decision
	logic [LEVEL_W:0] level_ext;
	logic [LEVEL_W:0] refill_thr;
	logic             low_buf;

	assign level_ext  = {1'b0, level_q};
	assign refill_thr = {1'b0, min_buffer_q} + {1'b0, margin_q};
	assign low_buf    = (level_q <= min_buffer_q) ||
	                    ((cnt_q == '0) && (level_ext < refill_thr));

	// layer scan compare
	logic [RATE_W-1:0]  cand_rate;
	logic [RATE_W+2:0]  cand_x5;
	logic [CMP_W-1:0]   cand_lhs;
	logic               cand_hit;
	logic [LAYER_W-1:0] best_nx;

	assign cand_rate = layer_rate_q[idx_q];
	assign cand_x5   = ({3'b0, cand_rate} << 2) + {3'b0, cand_rate};
	assign cand_lhs  = scaled_q ? {cand_x5, 8'b0} : {3'b0, cand_rate, 8'b0};
	assign cand_hit  = (cand_lhs < lim_q) && (cand_rate > best_rate_q);
	assign best_nx   = cand_hit ? idx_q : best_q;

	// pop
	logic [CNT_W-1:0]   cnt_pop;
	logic [LAYER_W-1:0] pop_layer;
	logic               seg_done;
	logic               out_free;

	assign cnt_pop   = (cnt_q != '0) ? cnt_q - CNT_W'(1) : '0;
	assign pop_layer = (cnt_q != '0) ? top_q - cnt_pop[LAYER_W-1:0] : '0;
	assign seg_done  = !(seg_q < total_seg_q);
	assign out_free  = !m_valid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, out_done_q, out_seg_q, out_layer_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_weight_q <= WEIGHT_RESET;
			min_buffer_q <= MIN_BUF_RESET;
			margin_q     <= '0;
			total_seg_q  <= '0;
			for (int i = 0; i < NUM_RATES; i++) layer_rate_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EMA_WEIGHT:     ema_weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_MIN_BUFFER:     min_buffer_q <= cfg_data[LEVEL_W-1:0];
				REG_GROWING_MARGIN: margin_q     <= cfg_data[LEVEL_W-1:0];
				REG_TOTAL_SEGMENTS: total_seg_q  <= cfg_data[SEG_W-1:0];
				REG_LAYER0_RATE:    layer_rate_q[0] <= cfg_data;
				REG_LAYER1_RATE:    layer_rate_q[1] <= cfg_data;
				REG_LAYER2_RATE:    layer_rate_q[2] <= cfg_data;
				REG_LAYER3_RATE:    layer_rate_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			avg_q     <= '0;
			cnt_q     <= '0;
			seg_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
					if (low_buf) begin
						cnt_q <= CNT_W'(1);
					end
				end
				ST_MUL2: begin
					avg_q   <= mac_y[AVG_W+7:8];
					state_q <= pick_q ? ST_LIM : ST_FIN;
				end
				ST_LIM: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q == LAYER_W'(MAX_LAYERS - 1)) begin
						cnt_q   <= CNT_W'(best_nx) + CNT_W'(1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						cnt_q     <= cnt_pop;
						if (!seg_done && cnt_pop == '0) seg_q <= seg_q + SEG_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					rate_q  <= s_tdata[RATE_W-1:0];
					level_q <= s_tdata[RATE_W+LEVEL_W-1:RATE_W];
					fill_q  <= s_tdata[RATE_W+LEVEL_W+FILL_W-1:RATE_W+LEVEL_W];
				end
			end
			ST_MUL1: begin
				acc_q    <= mac_y;
				pick_q   <= !low_buf && (cnt_q == '0);
				scaled_q <= fill_q > FILL_HALF;
				if (low_buf) top_q <= '0;
			end
			ST_LIM: begin
				lim_q       <= mac_y[CMP_W-1:0];
				idx_q       <= '0;
				best_q      <= '0;
				best_rate_q <= '0;
			end
			ST_SCAN: begin
				best_q <= best_nx;
				if (cand_hit) best_rate_q <= cand_rate;
				idx_q <= idx_q + LAYER_W'(1);
				if (idx_q == LAYER_W'(MAX_LAYERS - 1)) top_q <= best_nx;
			end
			ST_FIN: begin
				if (out_free) begin
					out_layer_q <= pop_layer;
					out_seg_q   <= seg_q;
					out_done_q  <= seg_done;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/lrap_checker.sv =====
// ----------------------------------------------------------------------------
// lrap_checker
// Port-level checks of the layered rate adaptation picker, bound to the top.
// ----------------------------------------------------------------------------
`include "layered_rate_adaptation_picker_assert.svh"

module lrap_checker #(
	parameter int MAX_LAYERS = 4
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lrap_pkg::M_DATA_W-1:0] m_tdata
);
	import lrap_pkg::*;

	logic in_xfer;
	logic out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// one request in flight: busy right after a transaction
	`LRAP_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_tready)

	// a result needs at least the two average steps
	`LRAP_ASSERT_NEXT(a_no_instant_result, in_xfer, !$rose(m_tvalid))

	// picked layer stays inside the configured layer count
	`LRAP_ASSERT_IMPLY(a_layer_range, m_tvalid, m_tdata[LAYER_W-1:0] <= LAYER_W'(MAX_LAYERS - 1))

	// stalled result holds
	`LRAP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// an output transfer only happens while a result is valid
	`LRAP_ASSERT_IMPLY(a_xfer_valid, out_xfer, m_tvalid)

endmodule

bind layered_rate_adaptation_picker lrap_checker #(.MAX_LAYERS(MAX_LAYERS)) u_lrap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
